// ----- src/tcf_pkg.sv -----
`default_nettype none
package tcf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int SQRT_STEPS   = 32;
	localparam int BLEND_SLOTS  = 5;
	localparam int CNT_W        = 5;

	localparam logic [2:0] REG_BIAS_X  = 3'd0;
	localparam logic [2:0] REG_BIAS_Y  = 3'd1;
	localparam logic [2:0] REG_BIAS_Z  = 3'd2;
	localparam logic [2:0] REG_ALPHA   = 3'd3;
	localparam logic [2:0] REG_GAIN_XY = 3'd4;
	localparam logic [2:0] REG_GAIN_Z  = 3'd5;

	localparam logic [15:0] ALPHA_RST   = 16'd58982;
	localparam logic [31:0] GAIN_XY_RST = 32'd1047553;
	localparam logic [31:0] GAIN_Z_RST  = 32'd21474836;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQUARE, ST_SQRT, ST_CINIT, ST_CORDIC, ST_BLEND, ST_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE, MUL_GX, MUL_GY, MUL_GZ, MUL_AX, MUL_TX, MUL_AY, MUL_TY
	} mul_op_t;

	typedef struct packed {
		logic             load;
		logic             square;
		logic             sqrt_step;
		logic             cordic_init;
		logic             cordic_step;
		logic [CNT_W-1:0] step;
		mul_op_t          mul_op;
		logic             commit;
	} cmd_t;

	function automatic logic [21:0] atan_lut(input logic [CNT_W-1:0] i);
		logic [21:0] r;
		case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [31:0] r;
		if (v > 37'sh007FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -37'sh0080000000) r = -32'sh80000000;
		else r = 32'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/tilt_complementary_filter.sv -----
`default_nettype none
// Six-axis tilt filter. Each accepted sample runs a bit-serial square root of the tilt
// magnitude while a shared 34x18 multiplier does the three gyro increments, then the
// vectoring CORDIC (X and Y tilts run side by side), then the four blend products on
// the multiplier. A sample is accepted whenever the block is idle; the angles stay on
// the output until taken, and the next result waits for that. Configuration writes are
// always taken (cfg_ready tied high); the user writes only while idle, not enforced.
module tilt_complementary_filter (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed [15:0]  accel_x,
	input  wire signed [15:0]  accel_y,
	input  wire signed [15:0]  accel_z,
	input  wire signed [15:0]  rate_x,
	input  wire signed [15:0]  rate_y,
	input  wire signed [15:0]  rate_z,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] angle_x,
	output logic signed [31:0] angle_y,
	output logic signed [31:0] angle_z,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [2:0]          cfg_index,
	input  wire [31:0]         cfg_data
);
	import tcf_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	tcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	tcf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z)
	);

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready)) else $error("result overwritten");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("result not presented");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("sample taken while busy");
	a_angles_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(angle_x) && $stable(angle_z)) else $error("angle moved");
`endif

endmodule
`default_nettype wire

// ----- src/tcf_tilt.sv -----
`default_nettype none
module tcf_tilt (
	input  wire                 clk,
	input  tcf_pkg::cmd_t       cmd,
	input  wire signed [16:0]   a,
	input  wire signed [15:0]   b,
	input  wire signed [15:0]   c,
	output logic signed [31:0]  t
);
	import tcf_pkg::*;

	logic [31:0]        sq_q;
	logic [35:0]        rem_q;
	logic [31:0]        root_q;
	logic signed [34:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic               zero_q;

	logic signed [31:0] bb, cc;
	logic [35:0]        rem_n, trial;
	logic signed [34:0] xs, ys;
	logic signed [31:0] ang;

	assign bb    = 32'(b) * 32'(b);
	assign cc    = 32'(c) * 32'(c);
	assign rem_n = {rem_q[33:0], sq_q[31:30]};
	assign trial = {2'b00, root_q, 2'b01};
	assign xs    = x_q >>> cmd.step;
	assign ys    = y_q >>> cmd.step;
	assign ang   = $signed({10'b0, atan_lut(cmd.step)});
	assign t     = zero_q ? 32'sd0 : z_q;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sq_q   <= $unsigned(bb) + $unsigned(cc);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_q <= {sq_q[29:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.cordic_init) begin
			x_q    <= $signed({3'b000, root_q});
			y_q    <= 35'(a) <<< 16;
			z_q    <= '0;
			zero_q <= (root_q == '0) && (a == '0);
		end else if (cmd.cordic_step) begin
			if (!y_q[34]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/tcf_datapath.sv -----
`default_nettype none
module tcf_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tcf_pkg::cmd_t       cmd,
	input  wire                 cfg_we,
	input  wire [2:0]           cfg_index,
	input  wire [31:0]          cfg_data,
	input  wire signed [15:0]   accel_x,
	input  wire signed [15:0]   accel_y,
	input  wire signed [15:0]   accel_z,
	input  wire signed [15:0]   rate_x,
	input  wire signed [15:0]   rate_y,
	input  wire signed [15:0]   rate_z,
	output logic signed [31:0]  angle_x,
	output logic signed [31:0]  angle_y,
	output logic signed [31:0]  angle_z
);
	import tcf_pkg::*;

	logic signed [15:0] bias_x_q, bias_y_q, bias_z_q;
	logic [15:0]        alpha_q;
	logic [31:0]        gain_xy_q, gain_z_q;
	logic signed [31:0] prev_x_q, prev_y_q, prev_z_q;

	logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q, rz_q;
	logic signed [33:0] gx_q, gy_q, gz_q;
	logic signed [51:0] acc_q;
	logic signed [31:0] new_x_q, new_y_q;
	logic signed [51:0] prod_s1;
	mul_op_t            op_s1;

	logic signed [31:0] tilt_x, tilt_y;
	logic signed [16:0] neg_ax, dx, dy, dz;
	logic signed [17:0] alpha_s, wgt_s;
	logic signed [33:0] gain_xy_s, gain_z_s;
	logic signed [33:0] a_op;
	logic signed [17:0] b_op;
	logic signed [35:0] inc;
	logic signed [52:0] sum;
	logic signed [36:0] blended;

	assign neg_ax    = -17'(ax_q);
	assign dx        = 17'(rx_q) - 17'(bias_x_q);
	assign dy        = 17'(ry_q) - 17'(bias_y_q);
	assign dz        = 17'(rz_q) - 17'(bias_z_q);
	assign alpha_s   = $signed({2'b00, alpha_q});
	assign wgt_s     = 18'sh10000 - alpha_s;
	assign gain_xy_s = $signed({2'b00, gain_xy_q});
	assign gain_z_s  = $signed({2'b00, gain_z_q});

	tcf_tilt u_tilt_x (.clk(clk), .cmd(cmd), .a(17'(ay_q)), .b(ax_q), .c(az_q), .t(tilt_x));
	tcf_tilt u_tilt_y (.clk(clk), .cmd(cmd), .a(neg_ax), .b(ay_q), .c(az_q), .t(tilt_y));

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.mul_op)
			MUL_GX: begin a_op = gain_xy_s;    b_op = 18'(dx);  end
			MUL_GY: begin a_op = gain_xy_s;    b_op = 18'(dy);  end
			MUL_GZ: begin a_op = gain_z_s;     b_op = 18'(dz);  end
			MUL_AX: begin a_op = gx_q;         b_op = alpha_s;  end
			MUL_TX: begin a_op = 34'(tilt_x);  b_op = wgt_s;    end
			MUL_AY: begin a_op = gy_q;         b_op = alpha_s;  end
			MUL_TY: begin a_op = 34'(tilt_y);  b_op = wgt_s;    end
			default: begin a_op = '0;          b_op = '0;       end
		endcase
	end

	assign inc     = 36'(prod_s1 >>> 16);
	assign sum     = 53'(acc_q) + 53'(prod_s1) + 53'sd32768;
	assign blended = 37'(sum >>> 16);

	always_ff @(posedge clk) begin
		prod_s1 <= 52'(a_op) * 52'(b_op);
		if (cmd.load) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			rx_q <= rate_x;
			ry_q <= rate_y;
			rz_q <= rate_z;
		end
		case (op_s1)
			MUL_GX: gx_q <= 34'(prev_x_q) + 34'(inc);
			MUL_GY: gy_q <= 34'(prev_y_q) + 34'(inc);
			MUL_GZ: gz_q <= 34'(prev_z_q) + 34'(inc);
			MUL_AX: acc_q <= prod_s1;
			MUL_AY: acc_q <= prod_s1;
			MUL_TX: new_x_q <= sat32(blended);
			MUL_TY: new_y_q <= sat32(blended);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1     <= MUL_NONE;
			bias_x_q  <= '0;
			bias_y_q  <= '0;
			bias_z_q  <= '0;
			alpha_q   <= ALPHA_RST;
			gain_xy_q <= GAIN_XY_RST;
			gain_z_q  <= GAIN_Z_RST;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			prev_z_q  <= '0;
		end else begin
			op_s1 <= cmd.mul_op;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BIAS_X:  bias_x_q  <= cfg_data[15:0];
					REG_BIAS_Y:  bias_y_q  <= cfg_data[15:0];
					REG_BIAS_Z:  bias_z_q  <= cfg_data[15:0];
					REG_ALPHA:   alpha_q   <= cfg_data[15:0];
					REG_GAIN_XY: gain_xy_q <= cfg_data;
					REG_GAIN_Z:  gain_z_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				prev_x_q <= new_x_q;
				prev_y_q <= new_y_q;
				prev_z_q <= sat32(37'(gz_q));
			end
		end
	end

	assign angle_x = prev_x_q;
	assign angle_y = prev_y_q;
	assign angle_z = prev_z_q;

endmodule
`default_nettype wire

// ----- src/tcf_ctrl.sv -----
`default_nettype none
module tcf_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	output tcf_pkg::cmd_t  cmd
);
	import tcf_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_CINIT;
			ST_CINIT:  state_d = ST_CORDIC;
			ST_CORDIC: if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) state_d = ST_BLEND;
			ST_BLEND:  if (cnt_q == CNT_W'(BLEND_SLOTS - 1)) state_d = ST_COMMIT;
			ST_COMMIT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQUARE: cmd.square = 1'b1;
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				case (cnt_q)
					5'd0:    cmd.mul_op = MUL_GX;
					5'd1:    cmd.mul_op = MUL_GY;
					5'd2:    cmd.mul_op = MUL_GZ;
					default: cmd.mul_op = MUL_NONE;
				endcase
			end
			ST_CINIT: cmd.cordic_init = 1'b1;
			ST_CORDIC: begin
				cmd.cordic_step = 1'b1;
				cmd.step        = cnt_q;
			end
			ST_BLEND: begin
				case (cnt_q)
					5'd0:    cmd.mul_op = MUL_AX;
					5'd1:    cmd.mul_op = MUL_TX;
					5'd2:    cmd.mul_op = MUL_AY;
					5'd3:    cmd.mul_op = MUL_TY;
					default: cmd.mul_op = MUL_NONE;
				endcase
			end
			ST_COMMIT: cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
